[rtl/core/lol_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lol_pkg;

   // Table size and field widths.
   localparam int ENTRIES = 64;
   localparam int SLOT_W  = 6;
   localparam int CNT_W   = 7;
   localparam int OP_W    = 2;
   localparam int ST_W    = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Status codes.
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
   localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

   // Write commands for the two link memories.
   typedef struct packed {
      logic              newer_we;
      logic [SLOT_W-1:0] newer_addr;
      logic [SLOT_W-1:0] newer_data;
      logic              older_we;
      logic [SLOT_W-1:0] older_addr;
      logic [SLOT_W-1:0] older_data;
   } link_wr_type;

   // Links of one slot as read from the memories.
   typedef struct packed {
      logic [SLOT_W-1:0] newer;
      logic [SLOT_W-1:0] older;
   } link_rd_type;

endpackage
`default_nettype wire

[rtl/core/lol_link_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module lol_link_mem
   import lol_pkg::*;
(
   input  wire logic              clock,
   input  wire link_wr_type       wr,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output link_rd_type            rd_data
);

   logic [SLOT_W-1:0] newer_mem [ENTRIES];
   logic [SLOT_W-1:0] older_mem [ENTRIES];
   link_rd_type       rd_data_ff;

   // One write port per memory.
   always_ff @(posedge clock) begin
      if (wr.newer_we) begin
         newer_mem[wr.newer_addr] <= wr.newer_data;
      end
      if (wr.older_we) begin
         older_mem[wr.older_addr] <= wr.older_data;
      end
   end

   // Registered read of both links of one slot.
   always_ff @(posedge clock) begin
      rd_data_ff.newer <= newer_mem[rd_addr];
      rd_data_ff.older <= older_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/lru_order_list.sv]
// A request that changes nothing goes from acceptance straight to S_FINISH; add, remove
// and touch of the back slot pass through S_EXEC, and a middle touch through S_EXEC and
// S_WRITE2, as each link memory has a single write port. A new request is taken only in
// S_IDLE, once the response register is loaded; S_FINISH waits while it is still full.
// Reset (synchronous, active high) empties the list: presence bits, front, back and
// count clear at once; the link memories keep their contents and need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module lru_order_list
   import lol_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [5:0] slot_index, [7:6] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [5:0] lru_slot, [11:6] mru_slot,
                                         // [18:12] occupancy, [23:19] zero
   output logic [2:0]       rsp_tuser    // [1:0] status, [2] list_nonempty
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_WRITE2 = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [ENTRIES-1:0] present_ff, present_in;
   logic [SLOT_W-1:0] front_ff, front_in;
   logic [SLOT_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ST_W-1:0]   status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_user_ff, rsp_user_in;

   logic [OP_W-1:0]   req_op;
   logic [SLOT_W-1:0] req_slot;
   logic              req_fire;
   logic              in_range;
   logic              present;
   logic              change;
   logic [ST_W-1:0]   decide_status;
   logic              nonempty;
   link_wr_type       wr;
   link_rd_type       links;
   logic [SLOT_W-1:0] rd_addr;

   assign req_op     = req_tuser;
   assign req_slot   = req_tdata[SLOT_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Links of the requested slot are read at the accept edge.
   assign rd_addr = (state_ff == S_IDLE) ? req_slot : slot_ff;

   lol_link_mem u_link_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (links)
   );

   // Status and whether the request modifies the list, from the request and the state registers.
   always_comb begin
      in_range      = ({1'b0, req_slot} < CNT_W'(ENTRIES));
      present       = in_range && present_ff[req_slot];
      decide_status = ST_OK;
      change        = 1'b0;
      case (req_op)
         OP_ADD: begin
            if (!in_range) begin
               decide_status = ST_ABSENT;
            end else if (present) begin
               decide_status = ST_DUP;
            end else begin
               change = 1'b1;
            end
         end
         OP_TOUCH, OP_REMOVE: begin
            if (count_ff == '0) begin
               decide_status = ST_EMPTY;
            end else if (!present) begin
               decide_status = ST_ABSENT;
            end else if (req_op == OP_TOUCH && req_slot == front_ff) begin
               change = 1'b0;
            end else begin
               change = 1'b1;
            end
         end
         default: begin
            change = 1'b0;
         end
      endcase
   end

   // Sequencer: read, an update in S_EXEC (and S_WRITE2 for a middle touch), then load the response register.
   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr           = '0;
      nonempty     = (count_ff != '0);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               slot_in   = req_slot;
               status_in = decide_status;
               state_in  = change ? S_EXEC : S_FINISH;
            end
         end

         S_EXEC: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_ADD: begin
                  present_in[slot_ff] = 1'b1;
                  count_in            = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     front_in = slot_ff;
                     back_in  = slot_ff;
                  end else begin
                     wr.newer_we   = 1'b1;
                     wr.newer_addr = front_ff;
                     wr.newer_data = slot_ff;
                     wr.older_we   = 1'b1;
                     wr.older_addr = slot_ff;
                     wr.older_data = front_ff;
                     front_in      = slot_ff;
                  end
               end
               OP_REMOVE: begin
                  present_in[slot_ff] = 1'b0;
                  count_in            = count_ff - 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     front_in = '0;
                     back_in  = '0;
                  end else if (slot_ff == front_ff) begin
                     front_in = links.older;
                  end else if (slot_ff == back_ff) begin
                     back_in = links.newer;
                  end else begin
                     wr.older_we   = 1'b1;
                     wr.older_addr = links.newer;
                     wr.older_data = links.older;
                     wr.newer_we   = 1'b1;
                     wr.newer_addr = links.older;
                     wr.newer_data = links.newer;
                  end
               end
               default: begin
                  // Touch of a slot behind the front: unlink, then relink at the front.
                  if (slot_ff == back_ff) begin
                     back_in       = links.newer;
                     wr.newer_we   = 1'b1;
                     wr.newer_addr = front_ff;
                     wr.newer_data = slot_ff;
                     wr.older_we   = 1'b1;
                     wr.older_addr = slot_ff;
                     wr.older_data = front_ff;
                     front_in      = slot_ff;
                  end else begin
                     wr.older_we   = 1'b1;
                     wr.older_addr = links.newer;
                     wr.older_data = links.older;
                     wr.newer_we   = 1'b1;
                     wr.newer_addr = links.older;
                     wr.newer_data = links.newer;
                     state_in      = S_WRITE2;
                  end
               end
            endcase
         end

         S_WRITE2: begin
            // Second half of a middle touch: link the slot in front.
            wr.newer_we   = 1'b1;
            wr.newer_addr = front_ff;
            wr.newer_data = slot_ff;
            wr.older_we   = 1'b1;
            wr.older_addr = slot_ff;
            wr.older_data = front_ff;
            front_in      = slot_ff;
            state_in      = S_FINISH;
         end

         default: begin
            // Wait until the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, count_ff,
                               nonempty ? front_ff : {SLOT_W{1'b0}},
                               nonempty ? back_ff : {SLOT_W{1'b0}}};
               rsp_user_in  = {nonempty, status_ff};
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

[rtl/core/lol_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module lol_checker
   import lol_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Occupancy never exceeds the table size.
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:12] <= CNT_W'(ENTRIES))
      else $error("occupancy above table size");

   // The nonempty flag agrees with the occupancy.
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2] == (rsp_tdata[18:12] != '0))
      else $error("nonempty flag disagrees with occupancy");

   // An empty list reports zero slots, and an empty status only on an empty list.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (!rsp_tuser[2] || rsp_tuser[1:0] == ST_EMPTY)
      |-> rsp_tdata[11:0] == '0 && rsp_tdata[18:12] == '0)
      else $error("empty list reports slots");

   // Only one request is in flight: the input closes right after an accept.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

endmodule

bind lru_order_list lol_checker u_lol_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
